// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kcl_pkg.sv -----
// Keypad code lock package: widths, key, status and mode codes, result struct.
// No dependencies.
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int CODE_LENGTH = 6;
  localparam int KEY_W       = 4;
  localparam int CNT_W       = 3;
  localparam int ATT_W       = 4;
  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 4;
  localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  localparam logic [ATT_W-1:0] ATTEMPT_LIMIT_RESET = 4'd3;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CANCEL    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_ERASE     = 4'd11;
  localparam logic [KEY_W-1:0] KEY_CHANGE    = 4'd12;
  localparam logic [KEY_W-1:0] KEY_CONFIRM   = 4'd13;

  localparam logic [MODE_W-1:0] M_ENTER  = 3'd0;
  localparam logic [MODE_W-1:0] M_OPEN   = 3'd1;
  localparam logic [MODE_W-1:0] M_NEW    = 3'd2;
  localparam logic [MODE_W-1:0] M_REPEAT = 3'd3;
  localparam logic [MODE_W-1:0] M_LOCKED = 3'd4;

  localparam logic [STATUS_W-1:0] S_DIGIT     = 4'd0;
  localparam logic [STATUS_W-1:0] S_FULL      = 4'd1;
  localparam logic [STATUS_W-1:0] S_ERASED    = 4'd2;
  localparam logic [STATUS_W-1:0] S_CLEARED   = 4'd3;
  localparam logic [STATUS_W-1:0] S_SHORT     = 4'd4;
  localparam logic [STATUS_W-1:0] S_WRONG     = 4'd5;
  localparam logic [STATUS_W-1:0] S_LOCKED    = 4'd6;
  localparam logic [STATUS_W-1:0] S_UNLOCKED  = 4'd7;
  localparam logic [STATUS_W-1:0] S_CHG_START = 4'd8;
  localparam logic [STATUS_W-1:0] S_NEW_TAKEN = 4'd9;
  localparam logic [STATUS_W-1:0] S_MISMATCH  = 4'd10;
  localparam logic [STATUS_W-1:0] S_CHANGED   = 4'd11;
  localparam logic [STATUS_W-1:0] S_IGNORED   = 4'd12;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    digit_count;
    logic [ATT_W-1:0]    failures;
    logic [MODE_W-1:0]   lock_mode;
    logic                alarm;
  } kcl_result_t;

endpackage

// ----- design/kcl_core.sv -----
// Lock state and single-pass next-state logic for one key transaction.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [kcl_pkg::KEY_W-1:0] key,
  input  logic                      cfg_wr_en,
  input  logic [kcl_pkg::ATT_W-1:0] cfg_wr_data,
  output kcl_pkg::kcl_result_t      result
);
  import kcl_pkg::*;

  logic [CODE_LENGTH-1:0][KEY_W-1:0] stored_code;
  logic [CODE_LENGTH-1:0][KEY_W-1:0] entry_digits;
  logic [CNT_W-1:0]                  entry_count;
  logic [CNT_W-1:0]                  entry_count_next;
  logic [ATT_W-1:0]                  attempts_left;
  logic [ATT_W-1:0]                  attempts_left_next;
  logic [MODE_W-1:0]                 mode;
  logic [MODE_W-1:0]                 mode_next;
  logic [ATT_W-1:0]                  attempt_limit;
  logic [STATUS_W-1:0]               status;
  logic                              wr_digit;
  logic                              copy_code;
  logic                              match;
  logic                              full;

  assign match = (entry_digits == stored_code);
  assign full  = (entry_count >= CNT_W'(CODE_LENGTH));

  always_comb begin
    entry_count_next   = entry_count;
    attempts_left_next = attempts_left;
    mode_next          = mode;
    status             = S_IGNORED;
    wr_digit           = 1'b0;
    copy_code          = 1'b0;
    if (mode == M_LOCKED) begin
      status = S_LOCKED;
    end else if (mode == M_OPEN) begin
      if (key == KEY_CHANGE) begin
        mode_next          = M_NEW;
        entry_count_next   = '0;
        attempts_left_next = attempt_limit;
        status             = S_CHG_START;
      end
    end else if (key <= KEY_DIGIT_MAX) begin
      if (!full) begin
        wr_digit         = 1'b1;
        entry_count_next = entry_count + 1'b1;
        status           = S_DIGIT;
      end else begin
        status = S_FULL;
      end
    end else if (key == KEY_CANCEL) begin
      if (entry_count != '0) begin
        entry_count_next = '0;
        status           = S_CLEARED;
      end
    end else if (key == KEY_ERASE) begin
      if (entry_count != '0) begin
        entry_count_next = entry_count - 1'b1;
        status           = S_ERASED;
      end
    end else if (key == KEY_CONFIRM) begin
      if (!full) begin
        status = S_SHORT;
      end else begin
        entry_count_next = '0;
        case (mode)
          M_ENTER: begin
            if (match) begin
              mode_next          = M_OPEN;
              attempts_left_next = attempt_limit;
              status             = S_UNLOCKED;
            end else if (attempts_left <= ATT_W'(1)) begin
              attempts_left_next = '0;
              mode_next          = M_LOCKED;
              status             = S_LOCKED;
            end else begin
              attempts_left_next = attempts_left - 1'b1;
              status             = S_WRONG;
            end
          end
          M_NEW: begin
            copy_code = 1'b1;
            mode_next = M_REPEAT;
            status    = S_NEW_TAKEN;
          end
          default: begin
            if (match) begin
              mode_next          = M_ENTER;
              attempts_left_next = attempt_limit;
              status             = S_CHANGED;
            end else begin
              status = S_MISMATCH;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    result.status      = status;
    result.digit_count = entry_count_next;
    result.failures    = (attempt_limit > attempts_left_next) ?
                         (attempt_limit - attempts_left_next) : '0;
    result.lock_mode   = mode_next;
    result.alarm       = (mode_next == M_LOCKED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= ATTEMPT_LIMIT_RESET;
      stored_code   <= '0;
      entry_count   <= '0;
      attempts_left <= ATTEMPT_LIMIT_RESET;
      mode          <= M_ENTER;
    end else begin
      if (cfg_wr_en) begin
        attempt_limit <= cfg_wr_data;
      end
      if (step) begin
        entry_count   <= entry_count_next;
        attempts_left <= attempts_left_next;
        mode          <= mode_next;
        if (copy_code) begin
          stored_code <= entry_digits;
        end
      end
    end
  end

  // entry buffer: no reset, read only once every place is written
  always_ff @(posedge clk) begin
    if (step && wr_digit) begin
      entry_digits[entry_count[IDX_W-1:0]] <= key;
    end
  end

endmodule

// ----- design/kcl_result_reg.sv -----
// Result register of the output channel, holds a transaction until taken.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_result_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  kcl_pkg::kcl_result_t result_in,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 free,
  output kcl_pkg::kcl_result_t result_out
);
  import kcl_pkg::*;

  kcl_result_t held;

  assign free       = !out_valid || out_ready;
  assign result_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result_in;
    end
  end

endmodule

// ----- design/keypad_code_lock_unit.sv -----
// Keypad code lock: one key transaction in, one result transaction out, at one
// transaction per cycle while the result side is not back-pressured. A key is
// registered on acceptance, then the state update and six-digit code compare
// run in a single combinational pass into the result register. The result
// register loads and raises out_valid when the registered key steps the core,
// after key-register acceptance; result back-pressure stalls the key register.
// No clearing pass after reset. Depends on kcl_pkg, kcl_core, kcl_result_reg.
`timescale 1ns / 1ps

module keypad_code_lock_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kcl_pkg::KEY_W-1:0]    key_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kcl_pkg::STATUS_W-1:0] status,
  output logic [kcl_pkg::CNT_W-1:0]    digit_count,
  output logic [kcl_pkg::ATT_W-1:0]    failures,
  output logic [kcl_pkg::MODE_W-1:0]   lock_mode,
  output logic                         alarm,
  input  logic                         cfg_wr_en,
  input  logic [kcl_pkg::ATT_W-1:0]    cfg_wr_data
);
  import kcl_pkg::*;

  logic             key_valid;
  logic [KEY_W-1:0] key_reg;
  logic             res_free;
  logic             step;
  kcl_result_t      res_next;
  kcl_result_t      res_out;

  assign step     = key_valid && res_free;
  assign in_ready = !key_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      key_valid <= 1'b1;
    end else if (step) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_reg <= key_code;
    end
  end

  kcl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .key         (key_reg),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (res_next)
  );

  kcl_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .result_in  (res_next),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .free       (res_free),
    .result_out (res_out)
  );

  assign status      = res_out.status;
  assign digit_count = res_out.digit_count;
  assign failures    = res_out.failures;
  assign lock_mode   = res_out.lock_mode;
  assign alarm       = res_out.alarm;

endmodule

// ----- design/kcl_checker.sv -----
// Port-level checks on the keypad code lock, bound to the top level.
// Depends on kcl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kcl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [kcl_pkg::STATUS_W-1:0] status,
  input logic [kcl_pkg::CNT_W-1:0]    digit_count,
  input logic [kcl_pkg::ATT_W-1:0]    failures,
  input logic [kcl_pkg::MODE_W-1:0]   lock_mode,
  input logic                         alarm
);
  import kcl_pkg::*;

  `ASSERT_IMPL(a_alarm_mode, clk, rst, out_valid,
               alarm == (lock_mode == M_LOCKED), "alarm disagrees with mode")
  `ASSERT_IMPL(a_locked_status, clk, rst, out_valid && lock_mode == M_LOCKED,
               status == S_LOCKED, "locked out but status not locked")
  `ASSERT_IMPL(a_unlock_clean, clk, rst, out_valid && status == S_UNLOCKED,
               lock_mode == M_OPEN && failures == '0 && digit_count == '0,
               "unlock result inconsistent")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
               out_valid && $stable(status) && $stable(lock_mode), "stalled result changed")
  `ASSERT_IMPL(a_in_stall, clk, rst, !in_ready,
               out_valid && !out_ready, "input stalled without output back-pressure")

endmodule

bind keypad_code_lock_unit kcl_checker u_kcl_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for keypad_code_lock_unit: key transactions in, lock
// results out, each checked against a cycle-free model of the lock or a typed row.
// Depends on kcl_pkg and the keypad_code_lock_unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import kcl_pkg::*;

  localparam logic [KEY_W-1:0] KEY_SPARE_A = 4'd14;
  localparam logic [KEY_W-1:0] KEY_SPARE_B = 4'd15;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS  = 40;

  typedef logic [CODE_LENGTH-1:0][KEY_W-1:0] code_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             typed;
    kcl_result_t      want;
  } key_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [KEY_W-1:0]    key_code;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    digit_count;
  logic [ATT_W-1:0]    failures;
  logic [MODE_W-1:0]   lock_mode;
  logic                alarm;
  logic                cfg_wr_en;
  logic [ATT_W-1:0]    cfg_wr_data;

  // lock model state
  logic [ATT_W-1:0]  limit_q    = ATTEMPT_LIMIT_RESET;
  logic [ATT_W-1:0]  attempts_q = ATTEMPT_LIMIT_RESET;
  logic [MODE_W-1:0] mode_q     = M_ENTER;
  logic [CNT_W-1:0]  count_q    = '0;
  code_t             code_q     = '0;
  code_t             entry_q    = '0;

  kcl_result_t lock_results_due [$];
  int  errors       = 0;
  int  results_seen = 0;
  int  keys_counted = 0;
  int  quiet_cycles = 0;
  int  hold_left    = 0;
  bit  hold_req     = 1'b0;
  bit  calm         = 1'b0;

  logic [ATT_W-1:0] phase_limits [6] = '{4'd15, 4'd1, 4'd0, 4'd7, 4'd9, 4'd3};

  key_row_t directed_rows [25] = '{
    '{KEY_SPARE_A, 1'b1, '{S_IGNORED, 3'd0, 4'd0, M_ENTER, 1'b0}},
    '{KEY_SPARE_B, 1'b1, '{S_IGNORED, 3'd0, 4'd0, M_ENTER, 1'b0}},
    '{KEY_CANCEL,  1'b1, '{S_IGNORED, 3'd0, 4'd0, M_ENTER, 1'b0}},
    '{KEY_ERASE,   1'b1, '{S_IGNORED, 3'd0, 4'd0, M_ENTER, 1'b0}},
    '{KEY_CHANGE,  1'b1, '{S_IGNORED, 3'd0, 4'd0, M_ENTER, 1'b0}},
    '{KEY_CONFIRM, 1'b1, '{S_SHORT,   3'd0, 4'd0, M_ENTER, 1'b0}},
    '{4'd9,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd5,        1'b1, '{S_FULL,    3'd6, 4'd0, M_ENTER, 1'b0}},
    '{KEY_ERASE,   1'b0, '0},
    '{4'd1,        1'b0, '0},
    '{KEY_CONFIRM, 1'b1, '{S_WRONG,   3'd0, 4'd1, M_ENTER, 1'b0}},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{4'd0,        1'b0, '0},
    '{KEY_CONFIRM, 1'b0, '0},
    '{4'd5,        1'b0, '0},
    '{KEY_CHANGE,  1'b0, '0}
  };

  keypad_code_lock_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key_code    (key_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .digit_count (digit_count),
    .failures    (failures),
    .lock_mode   (lock_mode),
    .alarm       (alarm),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic kcl_result_t apply_key(input logic [KEY_W-1:0] key);
    kcl_result_t         res;
    logic [STATUS_W-1:0] st;
    st = S_IGNORED;
    if (mode_q == M_LOCKED) begin
      st = S_LOCKED;
    end else if (mode_q == M_OPEN) begin
      if (key == KEY_CHANGE) begin
        mode_q     = M_NEW;
        count_q    = '0;
        attempts_q = limit_q;
        st         = S_CHG_START;
      end
    end else if (key <= KEY_DIGIT_MAX) begin
      if (count_q < CODE_LENGTH) begin
        entry_q[count_q] = key;
        count_q          = count_q + 1'b1;
        st               = S_DIGIT;
      end else begin
        st = S_FULL;
      end
    end else if (key == KEY_CANCEL) begin
      if (count_q != 0) begin
        count_q = '0;
        st      = S_CLEARED;
      end
    end else if (key == KEY_ERASE) begin
      if (count_q != 0) begin
        count_q = count_q - 1'b1;
        st      = S_ERASED;
      end
    end else if (key == KEY_CONFIRM) begin
      if (count_q < CODE_LENGTH) begin
        st = S_SHORT;
      end else begin
        count_q = '0;
        if (mode_q == M_ENTER) begin
          if (entry_q == code_q) begin
            mode_q     = M_OPEN;
            attempts_q = limit_q;
            st         = S_UNLOCKED;
          end else if (attempts_q <= 1) begin
            attempts_q = '0;
            mode_q     = M_LOCKED;
            st         = S_LOCKED;
          end else begin
            attempts_q = attempts_q - 1'b1;
            st         = S_WRONG;
          end
        end else if (mode_q == M_NEW) begin
          code_q = entry_q;
          mode_q = M_REPEAT;
          st     = S_NEW_TAKEN;
        end else if (entry_q == code_q) begin
          mode_q     = M_ENTER;
          attempts_q = limit_q;
          st         = S_CHANGED;
        end else begin
          st = S_MISMATCH;
        end
      end
    end
    res.status      = st;
    res.digit_count = count_q;
    res.failures    = (limit_q > attempts_q) ? limit_q - attempts_q : '0;
    res.lock_mode   = mode_q;
    res.alarm       = (mode_q == M_LOCKED);
    return res;
  endfunction

  function automatic code_t random_code();
    code_t c;
    for (int i = 0; i < CODE_LENGTH; i++) c[i] = $urandom_range(9);
    return c;
  endfunction

  // near miss or wholly different, never equal
  function automatic code_t other_code(input code_t c);
    code_t w;
    int    i;
    if ($urandom_range(1) == 0) begin
      w    = c;
      i    = $urandom_range(CODE_LENGTH - 1);
      w[i] = (c[i] == 4'd9) ? 4'd0 : c[i] + 4'd1;
    end else begin
      w = random_code();
      if (w == c) w[0] = (c[0] == 4'd9) ? 4'd0 : c[0] + 4'd1;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTS)
      $display("[%0t] result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
    errors++;
  endtask

  // one key transaction; prediction taken at the accepting edge
  task automatic push_key(input logic [KEY_W-1:0] k, input logic typed = 1'b0,
                          input kcl_result_t want = '0);
    kcl_result_t res;
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_code <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_key(k);
    lock_results_due.push_back(typed ? want : res);
    if (res.status != S_IGNORED) keys_counted++;
  endtask

  task automatic enter_code(input code_t c);
    if (count_q != 0) push_key(KEY_CANCEL);
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if ($urandom_range(9) == 0) begin
        push_key($urandom_range(9));
        push_key(KEY_ERASE);
      end
      if ($urandom_range(19) == 0) push_key(KEY_CONFIRM);
      push_key(c[i]);
    end
    if ($urandom_range(19) == 0) push_key($urandom_range(9));
    push_key(KEY_CONFIRM);
  endtask

  task automatic write_limit(input logic [ATT_W-1:0] v);
    in_valid <= 1'b0;
    while (lock_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_q = v;
  endtask

  task automatic run_phase(input int n_keys, input bit to_lockout, input bit hold_mid,
                           input bit drain_mid);
    int               start;
    int               r;
    bit               mid_done;
    logic [KEY_W-1:0] k;
    start    = keys_counted;
    mid_done = 1'b0;
    while (to_lockout ? (mode_q != M_LOCKED) : (keys_counted - start < n_keys)) begin
      r = $urandom_range(99);
      case (mode_q)
        M_OPEN: begin
          if (r < 15) push_key($urandom_range(15));
          else push_key(KEY_CHANGE);
        end
        M_NEW: enter_code(random_code());
        M_REPEAT: begin
          if (r < 80) enter_code(code_q);
          else enter_code(other_code(code_q));
        end
        M_ENTER: begin
          if (r < (to_lockout ? 15 : 45)) begin
            enter_code(code_q);
          end else if (r < (to_lockout ? 85 : 60) && (attempts_q > 1 || to_lockout)) begin
            enter_code(other_code(code_q));
          end else begin
            k = $urandom_range(15);
            // a stray full-buffer confirm must not lock out early
            if (k == KEY_CONFIRM && count_q == CODE_LENGTH && !to_lockout && attempts_q <= 1)
              k = KEY_CANCEL;
            push_key(k);
          end
        end
        default: push_key($urandom_range(15));
      endcase
      if (!mid_done && keys_counted - start >= 100) begin
        mid_done = 1'b1;
        if (hold_mid) hold_req = 1'b1;
        if (drain_mid) begin
          in_valid <= 1'b0;
          while (lock_results_due.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  // receiver: random back-pressure plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    kcl_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (lock_results_due.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        want = lock_results_due.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (digit_count !== want.digit_count)
          report_mismatch("digit_count", digit_count, want.digit_count);
        if (failures !== want.failures) report_mismatch("failures", failures, want.failures);
        if (lock_mode !== want.lock_mode) report_mismatch("lock_mode", lock_mode, want.lock_mode);
        if (alarm !== want.alarm) report_mismatch("alarm", alarm, want.alarm);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL keypad_code_lock_unit");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    key_code    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 25; i++)
      push_key(directed_rows[i].key, directed_rows[i].typed, directed_rows[i].want);

    // phase 1 runs without idling; lockout only in the last phase
    for (int p = 0; p < 6; p++) begin
      write_limit((p == 4) ? 4'($urandom_range(2, 14)) : phase_limits[p]);
      calm = (p == 1);
      run_phase(230, p == 5, p == 3, p == 4);
    end
    calm = 1'b0;
    repeat (40) push_key($urandom_range(15));
    in_valid <= 1'b0;

    while (lock_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS keypad_code_lock_unit");
    end else begin
      $display("FAIL keypad_code_lock_unit");
    end
    $finish;
  end

endmodule
